// ===== hw/rtl/cic_pkg.sv =====
// ----------------------------------------------------------------------------
// cic_pkg
// Shared types and constants of the CIC decimator.
// ----------------------------------------------------------------------------
package cic_pkg;

  // Width and reset value of the decimation ratio register
  localparam int unsigned RatioWidth = 7;
  localparam logic [RatioWidth-1:0] RatioReset = 7'd1;

  // Side-band control that travels with each sample through the cells
  typedef struct packed {
    logic valid;  // cell holds a sample
    logic dump;   // sample closes a decimation period
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/cic_integ_cell.sv =====
// ----------------------------------------------------------------------------
// cic_integ_cell
// One integrator cell: running sum plus an elastic output register.
// ----------------------------------------------------------------------------
module cic_integ_cell #(
  parameter int unsigned Width = 34
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cic_pkg::cell_ctrl_t in_ctrl_i,
  input  logic [Width-1:0]    in_data_i,
  output logic                in_ready_o,
  output cic_pkg::cell_ctrl_t out_ctrl_o,
  output logic [Width-1:0]    out_data_o,
  input  logic                out_ready_i
);

  logic [Width-1:0]    acc_q, acc_d;
  logic [Width-1:0]    data_q;
  cic_pkg::cell_ctrl_t ctrl_q;
  logic                take;

  assign in_ready_o = !ctrl_q.valid || out_ready_i;
  assign take       = in_ctrl_i.valid && in_ready_o;
  assign acc_d      = acc_q + in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      ctrl_q <= '0;
    end else if (take) begin
      acc_q  <= acc_d;
      ctrl_q <= in_ctrl_i;
    end else if (out_ready_i) begin
      ctrl_q.valid <= 1'b0;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= acc_d;
    end
  end

  assign out_ctrl_o = ctrl_q;
  assign out_data_o = data_q;

endmodule

// ===== hw/rtl/cic_comb_cell.sv =====
// ----------------------------------------------------------------------------
// cic_comb_cell
// One comb cell: first difference against the previous input it took.
// ----------------------------------------------------------------------------
module cic_comb_cell #(
  parameter int unsigned Width = 34
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [Width-1:0] in_data_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output logic [Width-1:0] out_data_o,
  input  logic             out_ready_i
);

  logic [Width-1:0] prev_q;
  logic [Width-1:0] data_q;
  logic             valid_q;
  logic             take;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      valid_q <= 1'b0;
    end else if (take) begin
      prev_q  <= in_data_i;
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= in_data_i - prev_q;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/cic_decimator_unit.sv =====
// ----------------------------------------------------------------------------
// cic_decimator_unit
// CIC decimator, order ORDER, differential delay one, full bit growth.
// ----------------------------------------------------------------------------
// Usage:
//   Input samples arrive on sample_in (valid/ready); one transaction per
//   cycle is sustained while the receiver does not stall. Each sample
//   runs through ORDER integrator cells. A phase counter at the input
//   marks every sample whose count reaches the decimation ratio; only
//   marked samples enter the ORDER comb cells, and each one leaves as one
//   transaction on sample_out (valid/ready). There is one register per
//   cell; throughput is one sample per cycle without stalls, set by the
//   single adder in each cell. Output is the raw sum with gain ratio^ORDER.
//   Every cell has its own valid bit and advances when empty or when its
//   neighbor takes its content, so a stalled receiver only freezes the
//   cells that are full; bubbles further up keep absorbing new input.
//   Reset clears integrators, comb delays, the phase counter and all valid
//   bits, and sets the ratio to one. Write the ratio through cfg_we_i and
//   cfg_wdata_i while idle; zero acts as one, values above MAX_RATIO
//   saturate. A changed ratio keeps the running phase count.
// ----------------------------------------------------------------------------
module cic_decimator_unit #(
  parameter int unsigned ORDER        = 3,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned MAX_RATIO    = 64,
  localparam int unsigned CntWidth    = $clog2(MAX_RATIO),
  localparam int unsigned ACC_WIDTH   = SAMPLE_WIDTH + ORDER * CntWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cic_pkg::RatioWidth-1:0]      cfg_wdata_i,
  input  logic                                sample_in_valid_i,
  output logic                                sample_in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  output logic                                sample_out_valid_o,
  input  logic                                sample_out_ready_i,
  output logic signed [ACC_WIDTH-1:0]         sample_out_o
);

  // Compare width: wide enough for the ratio register and for count + 1
  localparam int unsigned CmpWidth = (cic_pkg::RatioWidth > CntWidth + 1) ?
                                     cic_pkg::RatioWidth : CntWidth + 1;

  // ---------------------------------------------------------------- config
  logic [cic_pkg::RatioWidth-1:0] ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= cic_pkg::RatioReset;
    end else if (cfg_we_i) begin
      ratio_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------- phase count
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [CmpWidth-1:0] ratio_raw, ratio_eff, cnt_next;
  logic                dump;
  logic                in_take;

  assign ratio_raw = CmpWidth'(ratio_q);

  always_comb begin
    // Clamp ratio: zero acts as one, saturate at MAX_RATIO
    ratio_eff = ratio_raw;
    if (ratio_raw == '0) begin
      ratio_eff = CmpWidth'(1);
    end else if (ratio_raw > CmpWidth'(MAX_RATIO)) begin
      ratio_eff = CmpWidth'(MAX_RATIO);
    end
  end

  assign cnt_next = CmpWidth'(cnt_q) + CmpWidth'(1);
  assign dump     = (cnt_next >= ratio_eff);
  assign cnt_d    = dump ? '0 : cnt_next[CntWidth-1:0];
  assign in_take  = sample_in_valid_i && sample_in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_take) begin
      cnt_q <= cnt_d;
    end
  end

  // ------------------------------------------------------ integrator chain
  cic_pkg::cell_ctrl_t    integ_ctrl [ORDER+1];
  logic [ACC_WIDTH-1:0]   integ_data [ORDER+1];
  logic                   integ_rdy  [ORDER+1];

  assign integ_ctrl[0].valid = sample_in_valid_i;
  assign integ_ctrl[0].dump  = dump;
  // Sign-extend the sample to the accumulator width
  assign integ_data[0]       = {{(ACC_WIDTH-SAMPLE_WIDTH){sample_in_i[SAMPLE_WIDTH-1]}},
                                sample_in_i};
  assign sample_in_ready_o   = integ_rdy[0];

  for (genvar s = 0; s < ORDER; s++) begin : g_integ
    cic_integ_cell #(
      .Width(ACC_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_ctrl_i  (integ_ctrl[s]),
      .in_data_i  (integ_data[s]),
      .in_ready_o (integ_rdy[s]),
      .out_ctrl_o (integ_ctrl[s+1]),
      .out_data_o (integ_data[s+1]),
      .out_ready_i(integ_rdy[s+1])
    );
  end

  // ------------------------------------------------------------ comb chain
  logic                 comb_vld  [ORDER+1];
  logic [ACC_WIDTH-1:0] comb_data [ORDER+1];
  logic                 comb_rdy  [ORDER+1];

  // Only marked samples enter the combs; drop the others here
  assign comb_vld[0]      = integ_ctrl[ORDER].valid && integ_ctrl[ORDER].dump;
  assign comb_data[0]     = integ_data[ORDER];
  assign integ_rdy[ORDER] = comb_rdy[0] || !integ_ctrl[ORDER].dump;

  for (genvar s = 0; s < ORDER; s++) begin : g_comb
    cic_comb_cell #(
      .Width(ACC_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (comb_vld[s]),
      .in_data_i  (comb_data[s]),
      .in_ready_o (comb_rdy[s]),
      .out_valid_o(comb_vld[s+1]),
      .out_data_o (comb_data[s+1]),
      .out_ready_i(comb_rdy[s+1])
    );
  end

  // Last comb cell doubles as the output register
  assign sample_out_valid_o = comb_vld[ORDER];
  assign sample_out_o       = comb_data[ORDER];
  assign comb_rdy[ORDER]    = sample_out_ready_i;

endmodule

// ===== hw/rtl/cic_checker.sv =====
// ----------------------------------------------------------------------------
// cic_checker
// Port-level checks of the CIC decimator, bound to the top level.
// ----------------------------------------------------------------------------
module cic_checker #(
  parameter int unsigned OutWidth = 34
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                sample_in_valid_i,
  input logic                sample_in_ready_o,
  input logic                sample_out_valid_o,
  input logic                sample_out_ready_i,
  input logic [OutWidth-1:0] sample_out_o
);

  // Inputs taken minus outputs delivered
  logic [31:0] pend_q;
  logic        in_hs, out_hs;

  assign in_hs  = sample_in_valid_i && sample_in_ready_o;
  assign out_hs = sample_out_valid_o && sample_out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 32'(in_hs) - 32'(out_hs);
    end
  end

  // An output never appears without an earlier input behind it
  a_out_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_out_valid_o |-> pend_q != 32'd0)
    else $error("output without a pending input");

  // An empty or draining output register lets the input through
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!sample_out_valid_o || sample_out_ready_i) |-> sample_in_ready_o)
    else $error("input stalled while output is free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_out_valid_o && !sample_out_ready_i |=> sample_out_valid_o)
    else $error("output valid dropped before transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_out_valid_o && !sample_out_ready_i |=> $stable(sample_out_o))
    else $error("output payload changed while stalled");

endmodule

bind cic_decimator_unit cic_checker #(
  .OutWidth(ACC_WIDTH)
) u_cic_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .sample_in_valid_i (sample_in_valid_i),
  .sample_in_ready_o (sample_in_ready_o),
  .sample_out_valid_o(sample_out_valid_o),
  .sample_out_ready_i(sample_out_ready_i),
  .sample_out_o      (sample_out_o)
);

// ===== verif/tb_cic_decimator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_cic_decimator_unit
// Self-checking bench for the third-order CIC decimator. A bit-exact
// predictor runs on every accepted input transaction and queues the
// decimated samples it expects. A checker compares each output transaction
// with the oldest queued sample. The stimulus covers extreme samples, every
// ratio corner (zero, one, maximum, saturation), ratio changes in the middle
// of a count, random traffic under four idling mixes, and backpressure.
// ----------------------------------------------------------------------------
module tb_cic_decimator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Order         = 3;
  localparam int unsigned SampleWidth   = 16;
  localparam int unsigned MaxRatio      = 64;
  localparam int unsigned AccWidth      = 34;
  // Allow a safe margin before touching config.
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned MaxGap        = 40;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 4000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [cic_pkg::RatioWidth-1:0]    cfg_wdata_i = '0;
  logic                              sample_in_valid_i = 1'b0;
  logic                              sample_in_ready_o;
  logic signed [SampleWidth-1:0]     sample_in_i = '0;
  logic                              sample_out_valid_o;
  logic                              sample_out_ready_i = 1'b0;
  logic signed [AccWidth-1:0]        sample_out_o;

  // Idling mix and hold-off request, shared with the ready driver
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;

  // Predictor state: integrator sums, comb delays, phase and ratio register
  logic [AccWidth-1:0]            integ_sum [Order];
  logic [AccWidth-1:0]            comb_prev [Order];
  int unsigned                    phase_cnt = 0;
  logic [cic_pkg::RatioWidth-1:0] ratio_cfg = cic_pkg::RatioReset;

  // Decimated samples predicted but not yet seen on the output
  logic [AccWidth-1:0] pending_outputs_q [$];

  always #1 clk_i = ~clk_i;

  cic_decimator_unit #(
    .ORDER        (Order),
    .SAMPLE_WIDTH (SampleWidth),
    .MAX_RATIO    (MaxRatio)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .sample_in_valid_i  (sample_in_valid_i),
    .sample_in_ready_o  (sample_in_ready_o),
    .sample_in_i        (sample_in_i),
    .sample_out_valid_o (sample_out_valid_o),
    .sample_out_ready_i (sample_out_ready_i),
    .sample_out_o       (sample_out_o)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Map the raw register to the ratio in use: zero acts as one, large values
  // saturate at the maximum.
  function automatic int unsigned eff_ratio(input logic [cic_pkg::RatioWidth-1:0] r);
    if (r == '0) begin
      return 1;
    end else if (r > MaxRatio) begin
      return MaxRatio;
    end
    return r;
  endfunction

  // Advance the predicted filter by one sample; flag a decimated output
  task automatic predict_decimation(input logic signed [SampleWidth-1:0] x,
                                    output bit due,
                                    output logic [AccWidth-1:0] y);
    logic [AccWidth-1:0] v;
    logic [AccWidth-1:0] prev;
    // Sign-extend, then run the integrator chain; sums wrap at AccWidth
    integ_sum[0] = integ_sum[0] + AccWidth'(x);
    for (int s = 1; s < Order; s++) begin
      integ_sum[s] = integ_sum[s] + integ_sum[s-1];
    end
    due = 1'b0;
    y   = '0;
    if (phase_cnt + 1 < eff_ratio(ratio_cfg)) begin
      phase_cnt++;
    end else begin
      // Count reached (or passed, after a ratio change): wrap and dump
      phase_cnt = 0;
      v = integ_sum[Order-1];
      for (int s = 0; s < Order; s++) begin
        prev         = comb_prev[s];
        comb_prev[s] = v;
        v            = v - prev;
      end
      due = 1'b1;
      y   = v;
    end
  endtask

  initial begin
    for (int s = 0; s < Order; s++) begin
      integ_sum[s] = '0;
      comb_prev[s] = '0;
    end
  end

  // Track register writes and input transactions; queue predicted outputs
  always @(posedge clk_i) begin : p_input_monitor
    bit                  due;
    logic [AccWidth-1:0] y;
    if (rst_ni && cfg_we_i) begin
      ratio_cfg = cfg_wdata_i;
    end
    if (rst_ni && sample_in_valid_i && sample_in_ready_o) begin
      predict_decimation(sample_in_i, due, y);
      if (due) begin
        pending_outputs_q.push_back(y);
      end
    end
  end

  // Compare each output transaction with the oldest predicted sample
  always @(posedge clk_i) begin : p_output_checker
    logic [AccWidth-1:0] exp_val;
    if (rst_ni && sample_out_valid_o && sample_out_ready_i) begin
      if (pending_outputs_q.size() == 0) begin
        $error("unexpected output transaction: sample_out actual %0d",
               $signed(sample_out_o));
        err_count++;
      end else begin
        exp_val = pending_outputs_q.pop_front();
        if (sample_out_o !== exp_val) begin
          $error("sample_out mismatch: expected %0d, actual %0d",
                 $signed(exp_val), $signed(sample_out_o));
          err_count++;
        end
      end
    end
  end

  // Drive output ready: honor a long hold-off first, else stall at random
  always @(posedge clk_i) begin : p_ready_driver
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      sample_out_ready_i <= 1'b0;
    end else begin
      sample_out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin : p_watchdog
    if ((sample_in_valid_i && sample_in_ready_o) ||
        (sample_out_valid_o && sample_out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_cic_decimator_unit: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver helpers
  // --------------------------------------------------------------------------

  // Offer one sample after a random idle gap; return at its acceptance edge
  task automatic push_sample(input logic signed [SampleWidth-1:0] v);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < tx_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      sample_in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_in_valid_i <= 1'b1;
    sample_in_i       <= v;
    do @(posedge clk_i); while (!sample_in_ready_o);
  endtask

  // Mostly random samples, with full-scale runs to drive the sums to wrap
  function automatic logic signed [SampleWidth-1:0] rand_sample();
    case ($urandom_range(9))
      0, 1:    return 16'sh7FFF;
      2, 3:    return 16'sh8000;
      default: return SampleWidth'($urandom);
    endcase
  endfunction

  // Drop valid and wait until every predicted output has come out
  task automatic drain_outputs();
    sample_in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outputs_q.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then let the integrator cells settle so the block is idle
  task automatic wait_idle();
    drain_outputs();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_ratio(input logic [cic_pkg::RatioWidth-1:0] r);
    wait_idle();
    cfg_wdata_i <= r;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned tx, input int unsigned rx);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Extreme samples at the reset ratio, then ratio zero and ratio two
  task automatic test_extremes();
    logic signed [SampleWidth-1:0] vals [10];
    vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
             16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
    set_idling(0, 0);
    foreach (vals[i]) push_sample(vals[i]);
    // Zero ratio must behave as one: every sample dumps
    write_ratio('0);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sh1234);
    write_ratio(cic_pkg::RatioWidth'(2));
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh8000);
  endtask

  // Change the ratio in the middle of a count; the phase must carry over
  task automatic test_ratio_change();
    set_idling(0, 0);
    write_ratio(cic_pkg::RatioWidth'(4));
    push_sample(16'sh0100);
    push_sample(16'shFF00);
    // Count already reaches the new ratio: next sample dumps at once
    write_ratio(cic_pkg::RatioWidth'(2));
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    write_ratio(cic_pkg::RatioWidth'(3));
    push_sample(16'sh4000);
    // Raise the ratio mid-count: dump lands on the third sample
    write_ratio(cic_pkg::RatioWidth'(5));
    repeat (4) push_sample(rand_sample());
  endtask

  // Random traffic under four idling mixes, each with several ratios
  task automatic test_random_phases();
    int unsigned                    tx_pct [4];
    int unsigned                    rx_pct [4];
    logic [cic_pkg::RatioWidth-1:0] corner [4];
    logic [cic_pkg::RatioWidth-1:0] ratios [3];
    int unsigned                    e;
    int unsigned                    n;
    tx_pct = '{0, 77, 0, 38};
    rx_pct = '{0, 0, 77, 38};
    // Maximum, saturation, zero and one, one per mix
    corner = '{cic_pkg::RatioWidth'(MaxRatio), 7'h7F, 7'h00, 7'h01};
    for (int p = 0; p < 4; p++) begin
      set_idling(tx_pct[p], rx_pct[p]);
      ratios = '{cic_pkg::RatioWidth'($urandom_range(1, 8)), corner[p],
                 cic_pkg::RatioWidth'($urandom_range(0, 127))};
      foreach (ratios[k]) begin
        write_ratio(ratios[k]);
        // Large ratios get one dump and part of the next count
        e = eff_ratio(ratios[k]);
        n = (e <= 8) ? 30 : e + $urandom_range(1, e / 2);
        repeat (n) push_sample(rand_sample());
      end
    end
  endtask

  // Hold the receiver off for a long stretch while input keeps coming
  task automatic test_backpressure();
    set_idling(0, 0);
    write_ratio(cic_pkg::RatioWidth'(1));
    hold_request = HoldCycles;
    repeat (40) push_sample(rand_sample());
    wait_idle();
    set_idling(20, 50);
    hold_request = HoldCycles;
    write_ratio(cic_pkg::RatioWidth'(2));
    repeat (40) push_sample(rand_sample());
  endtask

  // Pause the sender until every predicted output has arrived, then resume
  task automatic test_sender_pause();
    set_idling(0, 38);
    write_ratio(cic_pkg::RatioWidth'(3));
    for (int k = 0; k < 4; k++) begin
      repeat (9 + k) push_sample(rand_sample());
      drain_outputs();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_ratio_change();
    test_random_phases();
    test_backpressure();
    test_sender_pause();
    wait_idle();
    if (err_count == 0 && pending_outputs_q.size() == 0) begin
      $display("tb_cic_decimator_unit: PASS");
    end else begin
      $display("tb_cic_decimator_unit: FAIL");
    end
    $finish;
  end

endmodule
